// ===== rtl/core/fcw_pkg.sv =====
// Shared types and constants for the FAT32 cluster chain walker.
// No dependencies; every module of the block imports this package.
`default_nettype none

package fcw_pkg;

	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned CLUSTER_W = 28;
	localparam int unsigned SLOT_W    = 7;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CS_W      = 8;

	// Table entries at or above this value mark the end of a chain.
	localparam logic [CLUSTER_W-1:0] CHAIN_END   = 28'hFFFFFF8;
	localparam logic [CLUSTER_W-1:0] FIRST_VALID = 28'd2;

	// Item operation codes.
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_NEXT  = 2'd1;
	localparam logic [1:0] OP_WORD  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PARTITION_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_COPIES    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_SECTORS = 3'd4;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_DATA  = 2'd1,
		PH_TABLE = 2'd2,
		PH_WAIT  = 2'd3
	} fcw_phase_t;

	typedef enum logic [2:0] {
		K_DATA   = 3'd0,
		K_TABLE  = 3'd1,
		K_ACCEPT = 3'd2,
		K_WAIT   = 3'd3,
		K_DONE   = 3'd4,
		K_UNEXP  = 3'd5
	} fcw_kind_t;

	// Volume layout derived from the configuration registers.
	typedef struct packed {
		logic [ADDR_W-1:0] table_start;
		logic [ADDR_W-1:0] data_base;
		logic [CS_W-1:0]   sectors;
	} fcw_layout_t;

	typedef struct packed {
		fcw_kind_t            kind;
		logic [ADDR_W-1:0]    sector_address;
		logic [SLOT_W-1:0]    entry_slot;
		logic [CLUSTER_W-1:0] cluster_now;
	} fcw_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/fcw_cfg_regs.sv =====
// Configuration registers of the chain walker and the volume layout built from them.
// Depends on fcw_pkg.
`default_nettype none

module fcw_cfg_regs
	import fcw_pkg::*;
#(
	parameter int unsigned MAX_CLUSTER_SECTORS = 128
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ADDR_W-1:0]    cfg_data,
	output fcw_layout_t               layout
);

	localparam logic [CS_W-1:0] SECTORS_CAP = CS_W'(MAX_CLUSTER_SECTORS);

	logic [ADDR_W-1:0] partition_start_q;
	logic [15:0]       reserved_count_q;
	logic [7:0]        table_copies_q;
	logic [ADDR_W-1:0] table_length_q;
	logic [CS_W-1:0]   cluster_sectors_q;
	logic [ADDR_W-1:0] tables_span_q;

	logic [7:0]        mul_a;
	logic [ADDR_W-1:0] mul_b;
	logic [39:0]       mul_p;

	// The size of all table copies is kept up to date at the write itself, so the
	// layout is valid in the cycle after any register write.
	always_comb begin
		mul_a = (cfg_index == REG_TABLE_COPIES) ? cfg_data[7:0] : table_copies_q;
		mul_b = (cfg_index == REG_TABLE_LENGTH) ? cfg_data : table_length_q;
		mul_p = 40'(mul_a) * 40'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partition_start_q <= '0;
			reserved_count_q  <= 16'd32;
			table_copies_q    <= 8'd2;
			table_length_q    <= '0;
			cluster_sectors_q <= 8'd1;
			tables_span_q     <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PARTITION_START: partition_start_q <= cfg_data;
				REG_RESERVED_COUNT:  reserved_count_q  <= cfg_data[15:0];
				REG_TABLE_COPIES: begin
					table_copies_q <= cfg_data[7:0];
					tables_span_q  <= mul_p[ADDR_W-1:0];
				end
				REG_TABLE_LENGTH: begin
					table_length_q <= cfg_data;
					tables_span_q  <= mul_p[ADDR_W-1:0];
				end
				REG_CLUSTER_SECTORS: cluster_sectors_q <= cfg_data[CS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		layout.table_start = partition_start_q + ADDR_W'(reserved_count_q);
		layout.data_base   = layout.table_start + tables_span_q;
		layout.sectors     = (cluster_sectors_q > SECTORS_CAP) ? SECTORS_CAP
		                                                       : cluster_sectors_q;
	end

endmodule

`default_nettype wire

// ===== rtl/core/fcw_step.sv =====
// Next-state and result logic of the chain walker for one item.
// Depends on fcw_pkg; purely combinational.
`default_nettype none

module fcw_step
	import fcw_pkg::*;
#(
	parameter int unsigned CNT_W = 8
) (
	input  wire fcw_layout_t           layout,
	input  wire logic [1:0]            op,
	input  wire logic [ADDR_W-1:0]     first_cluster,
	input  wire logic [ADDR_W-1:0]     table_word,
	input  wire logic [CLUSTER_W-1:0]  cluster_cur,
	input  wire logic [CNT_W-1:0]      count_cur,
	input  wire fcw_phase_t            phase_cur,
	output logic [CLUSTER_W-1:0]       cluster_nxt,
	output logic [CNT_W-1:0]           count_nxt,
	output fcw_phase_t                 phase_nxt,
	output fcw_result_t                result
);

	localparam int unsigned CMP_W = 9;

	logic                 start_ok;
	logic                 word_ok;
	logic [CLUSTER_W-1:0] word_cluster;
	logic [CLUSTER_W-1:0] rq_cluster;
	logic [CNT_W-1:0]     rq_count;
	fcw_phase_t           rq_phase;
	fcw_phase_t           rq_phase_eff;
	logic [CNT_W-1:0]     count_inc;
	logic [ADDR_W-1:0]    cluster_off;
	logic [39:0]          cluster_span;
	logic [ADDR_W-1:0]    data_lba;
	logic [ADDR_W-1:0]    table_lba;

	always_comb begin
		start_ok     = (first_cluster >= ADDR_W'(FIRST_VALID))
		             && (first_cluster < ADDR_W'(CHAIN_END));
		word_cluster = table_word[CLUSTER_W-1:0];
		word_ok      = (word_cluster >= FIRST_VALID) && (word_cluster < CHAIN_END);

		// A start item issues its first request from the freshly loaded cluster.
		if (op == OP_START) begin
			rq_cluster = first_cluster[CLUSTER_W-1:0];
			rq_count   = '0;
			rq_phase   = PH_DATA;
		end else begin
			rq_cluster = cluster_cur;
			rq_count   = count_cur;
			rq_phase   = phase_cur;
		end

		// A lowered sector count can leave the counter already at its end.
		if (rq_phase == PH_DATA && CMP_W'(rq_count) >= CMP_W'(layout.sectors)) begin
			rq_phase_eff = PH_TABLE;
		end else begin
			rq_phase_eff = rq_phase;
		end

		count_inc    = rq_count + CNT_W'(1);
		cluster_off  = ADDR_W'(rq_cluster) - ADDR_W'(FIRST_VALID);
		cluster_span = 40'(cluster_off) * 40'(layout.sectors);
		data_lba     = layout.data_base + cluster_span[ADDR_W-1:0] + ADDR_W'(rq_count);
		table_lba    = layout.table_start + ADDR_W'(rq_cluster[CLUSTER_W-1:SLOT_W]);

		cluster_nxt           = cluster_cur;
		count_nxt             = count_cur;
		phase_nxt             = phase_cur;
		result.kind           = K_DONE;
		result.sector_address = '0;
		result.entry_slot     = '0;

		priority if (op == OP_START && !start_ok) begin
			cluster_nxt = first_cluster[CLUSTER_W-1:0];
			count_nxt   = '0;
			phase_nxt   = PH_IDLE;
			result.kind = K_DONE;
		end else if (op == OP_WORD) begin
			if (phase_cur == PH_WAIT) begin
				// An end marker is still stored, so it shows on cluster_now.
				cluster_nxt = word_cluster;
				count_nxt   = '0;
				phase_nxt   = word_ok ? PH_DATA : PH_IDLE;
				result.kind = K_ACCEPT;
			end else begin
				result.kind = K_UNEXP;
			end
		end else begin
			cluster_nxt = rq_cluster;
			count_nxt   = rq_count;
			phase_nxt   = rq_phase_eff;
			unique case (rq_phase_eff)
				PH_DATA: begin
					result.kind           = K_DATA;
					result.sector_address = data_lba;
					count_nxt             = count_inc;
					phase_nxt = (CMP_W'(count_inc) >= CMP_W'(layout.sectors)) ? PH_TABLE
					                                                          : PH_DATA;
				end
				PH_TABLE: begin
					result.kind           = K_TABLE;
					result.sector_address = table_lba;
					result.entry_slot     = rq_cluster[SLOT_W-1:0];
					phase_nxt             = PH_WAIT;
				end
				PH_WAIT: result.kind = K_WAIT;
				PH_IDLE: result.kind = K_DONE;
				default: result.kind = K_DONE;
			endcase
		end

		result.cluster_now = cluster_nxt;
	end

endmodule

`default_nettype wire

// ===== rtl/core/fat32_cluster_chain_walker_unit.sv =====
// Top level of the FAT32 cluster chain walker: item register, walker state, result register.
// Depends on fcw_pkg, fcw_cfg_regs and fcw_step.
`default_nettype none

// Generates the sector reads that fetch a file along its FAT32 cluster chain.
// Program the volume layout through the write port while the block is idle; a
// write takes effect for items that leave the item register after it. A start item
// (op 0) loads a cluster, and while a chain is walked each start or next item
// (op 1) returns one request: the data sectors of the cluster one by one, then
// the table sector and word slot of its entry. Deliver that entry with an op 2
// item. Each item yields exactly one result. Throughput is one item per clock
// while the result side does not stall; an accepted item passes the item register
// and then the result register, with the address add and the cluster-times-sector-count
// multiply in between. The walker state updates as each item leaves the item
// register, so consecutive items chain without gaps.
module fat32_cluster_chain_walker_unit
	import fcw_pkg::*;
#(
	parameter int unsigned MAX_CLUSTER_SECTORS = 128
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ADDR_W-1:0]    cfg_data,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire logic [1:0]           op,
	input  wire logic [ADDR_W-1:0]    first_cluster,
	input  wire logic [ADDR_W-1:0]    table_word,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output logic [2:0]                kind,
	output logic [ADDR_W-1:0]         sector_address,
	output logic [SLOT_W-1:0]         entry_slot,
	output logic [CLUSTER_W-1:0]      cluster_now
);

	localparam int unsigned CNT_W = $clog2(MAX_CLUSTER_SECTORS + 1);

	fcw_layout_t          layout;
	logic                 valid_s1;
	logic [1:0]           op_s1;
	logic [ADDR_W-1:0]    first_s1;
	logic [ADDR_W-1:0]    word_s1;
	logic                 valid_s2;
	fcw_result_t          result_s2;
	logic [CLUSTER_W-1:0] cluster_q;
	logic [CNT_W-1:0]     count_q;
	fcw_phase_t           phase_q;
	logic [CLUSTER_W-1:0] cluster_d;
	logic [CNT_W-1:0]     count_d;
	fcw_phase_t           phase_d;
	fcw_result_t          result_d;
	logic                 advance;

	fcw_cfg_regs #(
		.MAX_CLUSTER_SECTORS(MAX_CLUSTER_SECTORS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.layout   (layout)
	);

	fcw_step #(
		.CNT_W(CNT_W)
	) u_step (
		.layout       (layout),
		.op           (op_s1),
		.first_cluster(first_s1),
		.table_word   (word_s1),
		.cluster_cur  (cluster_q),
		.count_cur    (count_q),
		.phase_cur    (phase_q),
		.cluster_nxt  (cluster_d),
		.count_nxt    (count_d),
		.phase_nxt    (phase_d),
		.result       (result_d)
	);

	// An item moves on when the result register is empty or being emptied.
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			cluster_q <= '0;
			count_q   <= '0;
			phase_q   <= PH_IDLE;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				valid_s2  <= 1'b1;
				cluster_q <= cluster_d;
				count_q   <= count_d;
				phase_q   <= phase_d;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			op_s1    <= op;
			first_s1 <= first_cluster;
			word_s1  <= table_word;
		end
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign result_valid   = valid_s2;
	assign kind           = result_s2.kind;
	assign sector_address = result_s2.sector_address;
	assign entry_slot     = result_s2.entry_slot;
	assign cluster_now    = result_s2.cluster_now;

endmodule

`default_nettype wire

// ===== tb/fat32_cluster_chain_walker_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for fat32_cluster_chain_walker_unit: a directed pass, then random chains.
// A scoreboard class predicts each result from the accepted items. Depends on fcw_pkg and the RTL.

module fat32_cluster_chain_walker_unit_test
	import fcw_pkg::*;
;

	localparam int unsigned SECTOR_CAP   = 128;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned HOLD_CYCLES  = 80;
	localparam int unsigned PHASE_ITEMS  = 125;
	localparam logic [1:0]  OP_NEXT_ALT  = 2'd3;  // Undefined op code, behaves as a next request.

	// Predicts the walker: volume layout, chain position and the queue of pending results.
	class chain_scoreboard;
		logic [31:0] part_start;
		logic [15:0] resv_count;
		logic [7:0]  copies;
		logic [31:0] tbl_len;
		logic [7:0]  clus_sec;
		logic [27:0] cur_cluster;
		logic [7:0]  sec_cnt;
		fcw_phase_t  walk_phase;
		fcw_result_t pending[$];
		int          mismatches;

		function new();
			part_start  = 32'd0;
			resv_count  = 16'd32;
			copies      = 8'd2;
			tbl_len     = 32'd0;
			clus_sec    = 8'd1;
			cur_cluster = '0;
			sec_cnt     = '0;
			walk_phase  = PH_IDLE;
			mismatches  = 0;
		endfunction

		function void set_register(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_PARTITION_START: part_start = data;
				REG_RESERVED_COUNT:  resv_count = data[15:0];
				REG_TABLE_COPIES:    copies = data[7:0];
				REG_TABLE_LENGTH:    tbl_len = data;
				REG_CLUSTER_SECTORS: clus_sec = data[7:0];
				default: ;
			endcase
		endfunction

		// Next read request of the chain, advancing through data sectors, table read and wait.
		function fcw_result_t issue_request();
			fcw_result_t r;
			logic [7:0]  eff;
			logic [31:0] tstart;
			logic [31:0] dstart;
			logic [31:0] offs;
			r.kind = K_DONE;
			r.sector_address = '0;
			r.entry_slot = '0;
			r.cluster_now = '0;
			eff = (clus_sec > 8'(SECTOR_CAP)) ? 8'(SECTOR_CAP) : clus_sec;
			tstart = part_start + 32'(resv_count);
			if (walk_phase == PH_DATA && sec_cnt >= eff)
				walk_phase = PH_TABLE;
			case (walk_phase)
				PH_DATA: begin
					dstart = tstart + 32'(copies) * tbl_len;
					r.kind = K_DATA;
					r.sector_address = dstart + (32'(cur_cluster) - 32'd2) * 32'(eff)
						+ 32'(sec_cnt);
					sec_cnt = sec_cnt + 8'd1;
					if (sec_cnt >= eff)
						walk_phase = PH_TABLE;
				end
				PH_TABLE: begin
					offs = 32'(cur_cluster) << 2;
					r.kind = K_TABLE;
					r.sector_address = tstart + (offs >> 9);
					r.entry_slot = offs[8:2];
					walk_phase = PH_WAIT;
				end
				PH_WAIT: r.kind = K_WAIT;
				default: r.kind = K_DONE;
			endcase
			return r;
		endfunction

		function void note_item(logic [1:0] op_code, logic [31:0] first, logic [31:0] word);
			fcw_result_t r;
			logic [27:0] nxt;
			r.kind = K_DONE;
			r.sector_address = '0;
			r.entry_slot = '0;
			r.cluster_now = '0;
			case (op_code)
				OP_START: begin
					cur_cluster = first[27:0];
					sec_cnt = '0;
					if (first >= 32'(FIRST_VALID) && first < 32'(CHAIN_END)) begin
						walk_phase = PH_DATA;
						r = issue_request();
					end else begin
						walk_phase = PH_IDLE;
					end
				end
				OP_WORD: begin
					if (walk_phase == PH_WAIT) begin
						nxt = word[27:0];
						cur_cluster = nxt;
						sec_cnt = '0;
						walk_phase = (nxt >= FIRST_VALID && nxt < CHAIN_END) ? PH_DATA : PH_IDLE;
						r.kind = K_ACCEPT;
					end else begin
						r.kind = K_UNEXP;
					end
				end
				default: r = issue_request();
			endcase
			r.cluster_now = cur_cluster;
			pending.push_back(r);
		endfunction

		function void check_result(logic [2:0] k, logic [31:0] addr, logic [6:0] slot,
			logic [27:0] clus);
			fcw_result_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d addr %h slot %0d cluster %h",
						k, addr, slot, clus);
				return;
			end
			e = pending.pop_front();
			if (k !== 3'(e.kind) || addr !== e.sector_address || slot !== e.entry_slot
				|| clus !== e.cluster_now) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch (expected/actual): kind %0d/%0d addr %h/%h slot %0d/%0d cluster %h/%h",
						e.kind, k, e.sector_address, addr, e.entry_slot, slot,
						e.cluster_now, clus);
			end
		endfunction

		// Results still owed at the end count as failures.
		function int wrap_up();
			return mismatches + pending.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;
	logic                 item_valid;
	logic                 item_ready;
	logic [1:0]           op;
	logic [ADDR_W-1:0]    first_cluster;
	logic [ADDR_W-1:0]    table_word;
	logic                 result_valid;
	logic                 result_ready;
	logic [2:0]           kind;
	logic [ADDR_W-1:0]    sector_address;
	logic [SLOT_W-1:0]    entry_slot;
	logic [CLUSTER_W-1:0] cluster_now;

	logic                 steady;
	int unsigned          hold_req;
	int unsigned          hold_seen;
	int unsigned          hold_left;
	int unsigned          idle_cycles;
	chain_scoreboard      sb;

	fat32_cluster_chain_walker_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.op             (op),
		.first_cluster  (first_cluster),
		.table_word     (table_word),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.kind           (kind),
		.sector_address (sector_address),
		.entry_slot     (entry_slot),
		.cluster_now    (cluster_now)
	);

	always #5 clk = ~clk;

	// Result side: random stalls, always ready in the steady phase, plus one long hold-off requested by the stimulus.
	initial begin
		result_ready = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (steady) begin
				result_ready <= 1'b1;
			end else begin
				result_ready <= ($urandom_range(99, 0) >= 27);
			end
		end
	end

	// Result checking and the stall watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				sb.check_result(kind, sector_address, entry_slot, cluster_now);
			if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_write)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_register(idx, data);
		@(posedge clk);
	endtask

	task automatic program_layout(input logic [31:0] ps, input logic [31:0] rc,
		input logic [31:0] tc, input logic [31:0] tl, input logic [31:0] cs);
		write_reg(REG_PARTITION_START, ps);
		write_reg(REG_RESERVED_COUNT, rc);
		write_reg(REG_TABLE_COPIES, tc);
		write_reg(REG_TABLE_LENGTH, tl);
		write_reg(REG_CLUSTER_SECTORS, cs);
		cfg_write <= 1'b0;
	endtask

	task automatic send_item(input logic [1:0] o, input logic [31:0] fc, input logic [31:0] tw);
		while (!steady && $urandom_range(99, 0) < 27) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		op <= o;
		first_cluster <= fc;
		table_word <= tw;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.note_item(o, fc, tw);
	endtask

	// Wait until every result is back, then let the pipeline empty.
	task automatic settle();
		item_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [27:0] random_cluster();
		case ($urandom_range(3, 0))
			0: return 28'($urandom_range(200, 2));
			1: return 28'($urandom_range(32'h0FFFFFF7, 32'h0FFFFF00));
			default: return 28'($urandom_range(32'h0FFFFFF7, 2));
		endcase
	endfunction

	function automatic logic [27:0] end_marker();
		case ($urandom_range(2, 0))
			0: return 28'd0;
			1: return 28'd1;
			default: return 28'($urandom_range(32'h0FFFFFFF, 32'h0FFFFFF8));
		endcase
	endfunction

	// Mostly well-formed chains that follow the walker's position, with some noise.
	task automatic pick_item(output logic [1:0] o, output logic [31:0] fc, output logic [31:0] tw);
		int unsigned r;
		r = $urandom_range(99, 0);
		o = OP_NEXT;
		fc = $urandom;
		tw = $urandom;
		if (r < 8) begin
			o = 2'($urandom_range(3, 0));
		end else begin
			case (sb.walk_phase)
				PH_IDLE: begin
					o = OP_START;
					if (r < 85)
						fc = {4'h0, random_cluster()};
					else if (r < 93)
						fc = {4'h0, end_marker()};
					else
						fc = {4'($urandom_range(15, 1)), 28'($urandom)};
				end
				PH_WAIT: begin
					if (r < 18) begin
						o = OP_NEXT;
					end else begin
						o = OP_WORD;
						tw = {4'($urandom), (r < 78) ? random_cluster() : end_marker()};
					end
				end
				default: o = (r < 14) ? OP_NEXT_ALT : OP_NEXT;
			endcase
		end
	endtask

	initial begin
		logic [1:0]  o;
		logic [31:0] fc;
		logic [31:0] tw;
		logic [7:0]  cs;
		int          failures;
		sb = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		op = '0;
		first_cluster = '0;
		table_word = '0;
		steady = 1'b0;
		hold_req = 0;
		idle_cycles = 0;
		repeat (9) @(posedge clk);
		// Release reset away from the rising edge.
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Reset layout: requests while idle, stray words, bad start clusters, then a short chain ended by an end marker.
		send_item(OP_NEXT, $urandom, $urandom);
		send_item(OP_WORD, $urandom, 32'h12345678);
		send_item(OP_NEXT_ALT, $urandom, $urandom);
		send_item(OP_START, 32'h0, $urandom);
		send_item(OP_START, 32'h1, $urandom);
		send_item(OP_START, 32'h0FFFFFF8, $urandom);
		send_item(OP_START, 32'hFFFFFFFF, $urandom);
		send_item(OP_START, 32'h2, $urandom);
		send_item(OP_NEXT, $urandom, $urandom);
		send_item(OP_NEXT_ALT, $urandom, $urandom);
		send_item(OP_WORD, $urandom, 32'hF0000003);
		send_item(OP_NEXT, $urandom, $urandom);
		send_item(OP_NEXT, $urandom, $urandom);
		send_item(OP_WORD, $urandom, 32'hFFFFFFFF);
		send_item(OP_NEXT, $urandom, $urandom);

		// Largest layout; the sector count saturates. The cluster size then shrinks
		// below the sectors already read, so the table read must come next.
		settle();
		program_layout(32'hFFFFFFFF, 32'hFFFF, 32'hFF, 32'hFFFFFFFF, 32'hFF);
		send_item(OP_START, 32'h0FFFFFF7, $urandom);
		send_item(OP_NEXT, $urandom, $urandom);
		send_item(OP_NEXT, $urandom, $urandom);
		settle();
		write_reg(REG_CLUSTER_SECTORS, 32'd2);
		cfg_write <= 1'b0;
		send_item(OP_NEXT, $urandom, $urandom);
		send_item(OP_WORD, $urandom, 32'h1);

		// All-zero layout: no data sectors, straight to the table reads.
		settle();
		program_layout(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		send_item(OP_START, 32'h10, $urandom);
		send_item(OP_WORD, $urandom, 32'h7F);
		send_item(OP_NEXT, $urandom, $urandom);
		send_item(OP_NEXT, $urandom, $urandom);
		send_item(OP_WORD, $urandom, 32'h0);
		send_item(OP_START, 32'h10000005, $urandom);

		for (int p = 0; p < 6; p++) begin
			settle();
			cs = (p == 4) ? 8'($urandom_range(255, 128)) : 8'($urandom_range(6, 0));
			program_layout($urandom, {16'($urandom), 16'($urandom)},
				{24'($urandom), 8'($urandom)}, $urandom, {24'($urandom), cs});
			steady <= (p == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == 40)
					hold_req <= hold_req + 1;
				pick_item(o, fc, tw);
				send_item(o, fc, tw);
			end
		end
		settle();
		repeat (8) @(posedge clk);

		failures = sb.wrap_up();
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== fat32_cluster_chain_walker_unit.f =====
rtl/core/fcw_pkg.sv
rtl/core/fcw_cfg_regs.sv
rtl/core/fcw_step.sv
rtl/core/fat32_cluster_chain_walker_unit.sv
tb/fat32_cluster_chain_walker_unit_test.sv
